FILE: sv/tlbpt_pkg.sv
// Shared constants, types and helper functions for the TLB page-table translator.
// No dependencies; the TLB, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

    localparam int VA_W        = 16;
    localparam int OFFSET_W    = 8;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
    localparam int TLB_ENTRIES = 16;
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int TAG_W       = 8;
    localparam int FRAME_W     = 8;
    localparam int TDATA_W     = ((VA_W + 7) / 8) * 8;
    localparam int TUSER_W     = 2;

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_lookup;

    typedef struct packed {
        logic               en;
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
    } t_tlb_fill;

    function automatic logic [PAGE_IDX_W-1:0] page_of(input logic [VA_W-1:0] va);
        logic [VA_W-1:0] sh;
        sh = va >> OFFSET_W;
        return sh[PAGE_IDX_W-1:0];
    endfunction

    function automatic logic [OFFSET_W-1:0] offset_of(input logic [VA_W-1:0] va);
        return va[OFFSET_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [PAGE_IDX_W-1:0] page);
        logic [31:0] w;
        w = 32'(page);
        return w[TAG_W-1:0];
    endfunction

    function automatic logic [VA_W-1:0] phys_of(input logic [FRAME_W-1:0] frame,
                                                input logic [OFFSET_W-1:0] offset);
        logic [31:0] w;
        w = (32'(frame) << OFFSET_W) | 32'(offset);
        return w[VA_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tlbpt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tlbpt_tlb.sv
// Fully associative TLB with valid bits and FIFO replacement.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_tlb (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tlbpt_pkg::TAG_W-1:0]  i_tag,
    input  wire tlbpt_pkg::t_tlb_fill         i_fill,
    output tlbpt_pkg::t_tlb_lookup            o_lookup
);

    logic [tlbpt_pkg::TAG_W-1:0]     r_tag   [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0]   r_frame [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] r_valid;
    logic [tlbpt_pkg::TLB_IDX_W-1:0] r_ptr;

    // The lowest-numbered matching entry wins.
    always_comb begin
        o_lookup = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_tag)) begin
                o_lookup.hit   = 1'b1;
                o_lookup.frame = r_frame[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_fill.en) begin
            r_valid[r_ptr] <= 1'b1;
            r_ptr          <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill.en) begin
            r_tag[r_ptr]   <= i_fill.tag;
            r_frame[r_ptr] <= i_fill.frame;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tlb_page_table_translator_top.sv
// Top level of the TLB-fronted page-table translator with demand paging.
// Depends on tlbpt_pkg, tlbpt_ram and tlbpt_tlb.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata                    tuser
// s_axis    in         virtual_address [15:0]   -
// m_axis    out        phys_addr [15:0]         tlb_hit [0], page_fault [1]
//
// An address is accepted in S_IDLE, where the page table RAM is read; S_RESOLVE then
// compares the TLB, resolves the frame and writes back the table and the TLB.
// Reset clears the TLB valid bits, the page table valid bits and both counters.
// A held result stalls the resolve state; no new address is taken while it waits.

module tlb_page_table_translator_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [tlbpt_pkg::TDATA_W-1:0]   s_axis_tdata,  // virtual_address
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [tlbpt_pkg::TDATA_W-1:0]   m_axis_tdata,  // phys_addr
    output logic      [tlbpt_pkg::TUSER_W-1:0]   m_axis_tuser   // tlb_hit, page_fault
);

    tlbpt_pkg::t_state                  r_state, n_state;
    logic [tlbpt_pkg::VA_W-1:0]         r_va;
    logic [tlbpt_pkg::PAGE_COUNT-1:0]   r_map_valid;
    logic [tlbpt_pkg::FRAME_W-1:0]      r_next_free;
    logic                               r_out_valid;
    logic [tlbpt_pkg::VA_W-1:0]         r_out_pa;
    logic                               r_out_hit;
    logic                               r_out_fault;

    logic                               accept;
    logic                               fire;
    logic                               fault;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]   page;
    logic [tlbpt_pkg::FRAME_W-1:0]      map_rd_frame;
    logic [tlbpt_pkg::FRAME_W-1:0]      frame;
    tlbpt_pkg::t_tlb_lookup             lookup;
    tlbpt_pkg::t_tlb_fill               fill;

    assign s_axis_tready = (r_state == tlbpt_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (r_state == tlbpt_pkg::S_RESOLVE) && (!r_out_valid || m_axis_tready);
    assign page          = tlbpt_pkg::page_of(r_va);
    assign fault         = !lookup.hit && !r_map_valid[page];

    always_comb begin
        if (lookup.hit) begin
            frame = lookup.frame;
        end else if (r_map_valid[page]) begin
            frame = map_rd_frame;
        end else begin
            frame = r_next_free;
        end
    end

    assign fill.en    = fire && !lookup.hit;
    assign fill.tag   = tlbpt_pkg::tag_of(page);
    assign fill.frame = frame;

    tlbpt_ram #(
        .WIDTH (tlbpt_pkg::FRAME_W),
        .DEPTH (tlbpt_pkg::PAGE_COUNT)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fire && fault),
        .i_wr_addr (page),
        .i_wr_data (r_next_free),
        .i_rd_en   (accept),
        .i_rd_addr (tlbpt_pkg::page_of(s_axis_tdata[tlbpt_pkg::VA_W-1:0])),
        .o_rd_data (map_rd_frame)
    );

    tlbpt_tlb u_tlb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tlbpt_pkg::tag_of(page)),
        .i_fill   (fill),
        .o_lookup (lookup)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbpt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = tlbpt_pkg::S_RESOLVE;
                end
            end
            tlbpt_pkg::S_RESOLVE: begin
                if (fire) begin
                    n_state = tlbpt_pkg::S_IDLE;
                end
            end
            default: n_state = tlbpt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlbpt_pkg::S_IDLE;
            r_map_valid <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire && fault) begin
                r_map_valid[page] <= 1'b1;
                r_next_free       <= r_next_free + 1'b1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_va <= s_axis_tdata[tlbpt_pkg::VA_W-1:0];
        end
        if (fire) begin
            r_out_pa    <= tlbpt_pkg::phys_of(frame, tlbpt_pkg::offset_of(r_va));
            r_out_hit   <= lookup.hit;
            r_out_fault <= fault;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = tlbpt_pkg::TDATA_W'(r_out_pa);
    assign m_axis_tuser  = {r_out_fault, r_out_hit};

    a_hit_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result flags both hit and fault");

    a_accept_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == tlbpt_pkg::S_RESOLVE))
        else $error("accepted address did not move to resolve");

    a_free_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && fault) |=> (r_next_free == tlbpt_pkg::FRAME_W'($past(r_next_free) + 1'b1)))
        else $error("free frame counter did not advance on a fault");

    a_hit_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tlbpt_pkg::S_RESOLVE) && lookup.hit) |-> r_map_valid[page])
        else $error("TLB hit on a page the table does not map");

endmodule

`default_nettype wire

FILE: tb/tlb_page_table_translator_top_tb.sv
// Self-checking testbench for the TLB page-table translator: a directed table of addresses,
// then locality-shaped random addresses; beats checked vs typed rows or a behavioural model.
// Depends on tlbpt_pkg and tlb_page_table_translator_top.
`timescale 1ns / 1ps

module tlb_page_table_translator_top_tb;

    localparam int VA_W           = tlbpt_pkg::VA_W;
    localparam int OFF_W          = tlbpt_pkg::OFFSET_W;
    localparam int FRAME_W        = tlbpt_pkg::FRAME_W;
    localparam int TLB_SLOTS      = tlbpt_pkg::TLB_ENTRIES;
    localparam int PAGES          = tlbpt_pkg::PAGE_COUNT;
    localparam int RANDOM_ITEMS   = 1680;
    localparam int QUIET_ITEMS    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [VA_W-1:0] phys;
        logic            hit;
        logic            fault;
    } t_xlate;

    typedef struct packed {
        logic [VA_W-1:0] va;
        logic            typed_in;
        t_xlate          want;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    t_dir_row directed_rows [0:DIR_ROWS-1] = '{
        '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0}},
        '{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1}},
        '{16'hFF00, 1'b1, '{16'h0100, 1'b1, 1'b0}},
        '{16'h01A5, 1'b0, '0},
        '{16'h025A, 1'b0, '0},
        '{16'h0333, 1'b0, '0},
        '{16'h04CC, 1'b0, '0},
        '{16'h0501, 1'b0, '0},
        '{16'h06FE, 1'b0, '0},
        '{16'h0780, 1'b0, '0},
        '{16'h087F, 1'b0, '0},
        '{16'h0910, 1'b0, '0},
        '{16'h0AEF, 1'b0, '0},
        '{16'h0B55, 1'b0, '0},
        '{16'h0CAA, 1'b0, '0},
        '{16'h0D0F, 1'b0, '0},
        '{16'h0EF0, 1'b0, '0},
        '{16'h0F00, 1'b0, '0},
        '{16'h0012, 1'b1, '{16'h0012, 1'b0, 1'b0}},
        '{16'hFF34, 1'b1, '{16'h0134, 1'b0, 1'b0}},
        '{16'h0F80, 1'b0, '0},
        '{16'h8000, 1'b0, '0}
    };

    logic                              i_clk;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [tlbpt_pkg::TDATA_W-1:0]     s_axis_tdata  = '0;  // virtual_address
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [tlbpt_pkg::TDATA_W-1:0]     m_axis_tdata;        // phys_addr
    logic [tlbpt_pkg::TUSER_W-1:0]     m_axis_tuser;        // tlb_hit, page_fault

    bit   [7:0]         tlb_tag     [TLB_SLOTS];
    bit   [FRAME_W-1:0] tlb_frame   [TLB_SLOTS];
    bit                 tlb_live    [TLB_SLOTS];
    int unsigned        fill_slot;
    bit                 page_mapped [PAGES];
    bit   [FRAME_W-1:0] page_frame  [PAGES];
    bit   [FRAME_W-1:0] free_frame;

    t_xlate      expected_results [$];
    bit          bursty = 1'b1;
    bit   [7:0]  hot_pages  [8];
    bit   [7:0]  warm_pages [32];
    bit   [7:0]  sweep_page;
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned tlb_hit_count;
    int unsigned table_hits;
    int unsigned faults;
    int unsigned frame_wraps;
    int unsigned idle_cycles;

    tlb_page_table_translator_top i_dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_xlate predict_translation(input logic [VA_W-1:0] va);
        logic [OFF_W-1:0]   offset;
        logic [7:0]         page;
        logic [FRAME_W-1:0] frame;
        logic [31:0]        wide;
        t_xlate             r;
        offset = va[OFF_W-1:0];
        page   = 8'((va >> OFF_W) % PAGES);
        frame  = '0;
        r      = '0;
        for (int i = 0; i < TLB_SLOTS; i++) begin
            if (!r.hit && tlb_live[i] && tlb_tag[i] == page) begin
                frame = tlb_frame[i];
                r.hit = 1'b1;
            end
        end
        if (r.hit) begin
            tlb_hit_count++;
        end else begin
            if (page_mapped[page]) begin
                frame = page_frame[page];
                table_hits++;
            end else begin
                r.fault           = 1'b1;
                frame             = free_frame;
                page_mapped[page] = 1'b1;
                page_frame[page]  = frame;
                free_frame++;
                if (free_frame == 0) begin
                    frame_wraps++;
                end
                faults++;
            end
            tlb_tag[fill_slot]   = page;
            tlb_frame[fill_slot] = frame;
            tlb_live[fill_slot]  = 1'b1;
            fill_slot            = (fill_slot + 1) % TLB_SLOTS;
        end
        wide   = (32'(frame) << OFF_W) | 32'(offset);
        r.phys = wide[VA_W-1:0];
        return r;
    endfunction

    function automatic logic [VA_W-1:0] pick_address();
        logic [7:0]  page;
        logic [7:0]  offset;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            page = hot_pages[$urandom_range(0, 7)];
        end else if (roll < 65) begin
            page = warm_pages[$urandom_range(0, 31)];
        end else if (roll < 80) begin
            page = 8'($urandom);
        end else begin
            page = sweep_page;
            sweep_page++;
        end
        case ($urandom_range(0, 7))
            0: begin
                offset = '0;
            end
            1: begin
                offset = '1;
            end
            default: begin
                offset = 8'($urandom);
            end
        endcase
        return {page, offset};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_address(input logic [VA_W-1:0] va, input bit typed_in,
                                input t_xlate want);
        t_xlate modelled;
        s_axis_tdata  <= va;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        modelled = predict_translation(va);
        expected_results.push_back(typed_in ? want : modelled);
        if (bursty && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    initial begin
        @(posedge i_clk);
        forever begin
            if (bursty && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_xlate want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[VA_W-1:0] !== want.phys) begin
                    report_mismatch("phys_addr", m_axis_tdata, want.phys);
                end
                if (m_axis_tuser[0] !== want.hit) begin
                    report_mismatch("tlb_hit", m_axis_tuser[0], want.hit);
                end
                if (m_axis_tuser[1] !== want.fault) begin
                    report_mismatch("page_fault", m_axis_tuser[1], want.fault);
                end
                beats_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int n;
        foreach (hot_pages[k]) hot_pages[k] = 8'($urandom);
        foreach (warm_pages[k]) warm_pages[k] = 8'($urandom);
        sweep_page = 8'($urandom);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            send_address(directed_rows[r].va, directed_rows[r].typed_in, directed_rows[r].want);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                bursty = 1'b0;
            end else if (n % 150 == 0) begin
                bursty = ($urandom_range(0, 3) != 0);
            end
            if (n % 32 == 0) begin
                hot_pages[$urandom_range(0, 7)] = 8'($urandom);
            end
            if (n % 16 == 0) begin
                warm_pages[$urandom_range(0, 31)] = 8'($urandom);
            end
            send_address(pick_address(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Translated %0d addresses (%0d directed): %0d TLB hits, %0d page-table hits, %0d faults.",
                 DIR_ROWS + RANDOM_ITEMS, DIR_ROWS, tlb_hit_count, table_hits, faults);
        $display("%0d result beats checked; frame allocator wrapped %0d time(s), next frame %0d.",
                 beats_checked, frame_wraps, free_frame);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
